// ----- rtl/gcc_pkg.sv -----
// Shared types and constants for the graph connectivity checker.
`default_nettype none

package gcc_pkg;

    localparam int NODE_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Transaction kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Per-cycle command broadcast to every node cell
    typedef struct packed {
        logic start;   // reset visited set to the root node
        logic write;   // set the symmetric edge bits of the selected pair
        logic expand;  // grow the visited set by one hop
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- rtl/gcc_cell.sv -----
// Node cell: one adjacency row and the node's visited bit, with one-hop growth.
`default_nettype none

module gcc_cell
    import gcc_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int INDEX     = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_cmd            i_cmd,
    input  wire logic                 i_sel_a,
    input  wire logic                 i_sel_b,
    input  wire logic [MAX_NODES-1:0] i_onehot_a,
    input  wire logic [MAX_NODES-1:0] i_onehot_b,
    input  wire logic [MAX_NODES-1:0] i_active_mask,
    input  wire logic                 i_self_active,
    input  wire logic [MAX_NODES-1:0] i_visited_vec,
    output logic                      o_visited,
    output logic                      o_grow,
    output logic                      o_hit
);

    logic [MAX_NODES-1:0] r_row;
    logic [MAX_NODES-1:0] n_row;
    logic                 r_visited;
    logic                 n_visited;

    // A neighbor that is active and already visited pulls this node in
    assign o_grow    = i_self_active & ~r_visited
                     & (|(r_row & i_visited_vec & i_active_mask));
    assign o_hit     = i_sel_a & (|(r_row & i_onehot_b));
    assign o_visited = r_visited;

    always_comb begin
        n_row = r_row;
        if (i_cmd.write) begin
            if (i_sel_a) begin
                n_row = n_row | i_onehot_b;
            end
            if (i_sel_b) begin
                n_row = n_row | i_onehot_a;
            end
        end
    end

    always_comb begin
        n_visited = r_visited;
        if (i_cmd.start) begin
            n_visited = (INDEX == 0);
        end else if (i_cmd.expand) begin
            n_visited = r_visited | o_grow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= {{(MAX_NODES-1){1'b0}}, 1'b1} << INDEX;
            r_visited <= 1'b0;
        end else begin
            r_row     <= n_row;
            r_visited <= n_visited;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/graph_connectivity_checker.sv -----
// Flow: an accepted transaction starts a walk that grows the visited set hop by hop from node 0;
//   the walk ends once no cell grows, and the result then loads into the output register (S_HOLD while stalled).
// Throughput: the input stalls from acceptance until the result loads, so only one transaction walks at a time.
//   The walk length is set by the hop distance from node 0 through the node cell row.
// Reset (synchronous, active low): adjacency back to self-loops only, node_count 64,
//   output empty; the block accepts a transaction as soon as reset is released.
`default_nettype none

module graph_connectivity_checker
    import gcc_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic [NODE_W-1:0]  i_node_a,
    input  wire logic [NODE_W-1:0]  i_node_b,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_adjacent,
    output logic                    o_all_connected,
    output logic                    o_bad_index
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    t_state               r_state;
    logic [COUNT_W-1:0]   r_node_count;
    logic [MAX_NODES-1:0] r_active;
    logic                 r_pend_adj;
    logic                 r_pend_bad;
    logic                 r_out_valid;
    logic                 r_out_adj;
    logic                 r_out_all;
    logic                 r_out_bad;

    logic [MAX_NODES-1:0] w_onehot_a;
    logic [MAX_NODES-1:0] w_onehot_b;
    logic [MAX_NODES-1:0] w_active_now;
    logic [MAX_NODES-1:0] w_visited;
    logic [MAX_NODES-1:0] w_grow;
    logic [MAX_NODES-1:0] w_hit;
    logic                 w_in_accept;
    logic                 w_bad;
    logic                 w_adj;
    logic                 w_all;
    logic                 w_out_free;
    logic                 w_load;
    t_cell_cmd            w_cmd;

    genvar j;
    generate
        for (j = 0; j < MAX_NODES; j++) begin : g_dec
            assign w_onehot_a[j]   = (32'(i_node_a) == j);
            assign w_onehot_b[j]   = (32'(i_node_b) == j);
            // node_count of zero still keeps node 0 active
            assign w_active_now[j] = (j == 0) || (j < 32'(r_node_count));
        end
    endgenerate

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_bad       = ~(|(w_onehot_a & w_active_now)) | ~(|(w_onehot_b & w_active_now));
    assign w_adj       = ~w_bad & ((i_kind == KIND_ADD) | (|w_hit));
    assign w_all       = &(w_visited | ~r_active);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = w_out_free
                       && (((r_state == S_WALK) && !(|w_grow)) || (r_state == S_HOLD));

    assign w_cmd.start  = w_in_accept;
    assign w_cmd.write  = w_in_accept && (i_kind == KIND_ADD) && !w_bad;
    assign w_cmd.expand = (r_state == S_WALK);

    genvar i;
    generate
        for (i = 0; i < MAX_NODES; i++) begin : g_cell
            gcc_cell #(
                .MAX_NODES (MAX_NODES),
                .INDEX     (i)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_sel_a       (w_onehot_a[i]),
                .i_sel_b       (w_onehot_b[i]),
                .i_onehot_a    (w_onehot_a),
                .i_onehot_b    (w_onehot_b),
                .i_active_mask (r_active),
                .i_self_active (r_active[i]),
                .i_visited_vec (w_visited),
                .o_visited     (w_visited[i]),
                .o_grow        (w_grow[i]),
                .o_hit         (w_hit[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= COUNT_RESET;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            // drop the result once taken unless a new one loads in the same cycle
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_pend_adj <= w_adj;
                        r_pend_bad <= w_bad;
                        r_active   <= w_active_now;
                        r_state    <= S_WALK;
                    end
                end
                S_WALK: begin
                    // walk is done once no cell grows
                    if (!(|w_grow)) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_adj   <= r_pend_adj;
                            r_out_all   <= w_all;
                            r_out_bad   <= r_pend_bad;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_adj   <= r_pend_adj;
                        r_out_all   <= w_all;
                        r_out_bad   <= r_pend_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_adjacent      = r_out_adj;
    assign o_all_connected = r_out_all;
    assign o_bad_index     = r_out_bad;

    a_root_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> w_visited[0])
        else $error("root node not visited during walk");

    a_visited_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && $past(r_state) == S_WALK)
            |-> ((w_visited & $past(w_visited)) == $past(w_visited)))
        else $error("visited set lost a node during walk");

    a_visited_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_HOLD) |-> ((w_visited & ~r_active) == '0))
        else $error("inactive node marked visited");

    a_bad_not_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> !r_out_adj)
        else $error("bad index reported as adjacent");

endmodule

`default_nettype wire
